// ===== src/swd_pkg.sv =====
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types, constants and lookup tables for the sample word deinterleaver.
// ----------------------------------------------------------------------------
package swd_pkg;

  // group geometry
  localparam int GROUP_WORDS        = 6;
  localparam int STORE_WORDS        = GROUP_WORDS - 1;
  localparam int GROUP_SAMPLES      = 16;
  localparam int SAMPLE_W           = 12;
  localparam int GROUP_BITS         = 32 * GROUP_WORDS;
  localparam int CHANNELS_PER_FIBER = 8;
  localparam int CHAN_W             = $clog2(CHANNELS_PER_FIBER);

  // output field widths
  localparam int FIBER_W  = 5;
  localparam int CIDX_W   = FIBER_W + CHAN_W;
  localparam int SIDX_W   = 5;
  localparam int M_W      = $clog2(GROUP_SAMPLES);

  // word kind codes
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
  } in_t;

  typedef struct packed {
    logic [FIBER_W-1:0]  fiber;
    logic [CHAN_W-1:0]   channel;
    logic [CIDX_W-1:0]   channel_index;
    logic [SIDX_W-1:0]   sample_index;
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_of_group;
  } out_t;

  // one complete group handed from front to back
  typedef struct packed {
    logic [GROUP_BITS-1:0] grp;
    logic [FIBER_W-2:0]    pair_lo;
    logic [SIDX_W-1:0]     sample_index;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // fiber offset within the pair for sample m of a group
  function automatic logic fiber_sel(input logic [M_W-1:0] m);
    logic r;
    case (m)
      4'd2, 4'd3, 4'd6, 4'd7, 4'd10, 4'd11, 4'd14, 4'd15: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // converter channel for sample m of a group
  function automatic logic [CHAN_W-1:0] chan_sel(input logic [M_W-1:0] m);
    logic [CHAN_W-1:0] r;
    case (m)
      4'd0, 4'd2:   r = 3'd1;
      4'd1, 4'd3:   r = 3'd0;
      4'd4, 4'd6:   r = 3'd3;
      4'd5, 4'd7:   r = 3'd2;
      4'd8, 4'd10:  r = 3'd5;
      4'd9, 4'd11:  r = 3'd4;
      4'd12, 4'd14: r = 3'd7;
      default:      r = 3'd6;
    endcase
    return r;
  endfunction

endpackage

// ===== src/swd_front.sv =====
// ----------------------------------------------------------------------------
// swd_front
// Accepts header and data words, keeps the counters and collects six data
// words into one group request for the back end.
// ----------------------------------------------------------------------------
module swd_front import swd_pkg::*; #(
  parameter int FIBERS      = 20,
  parameter int MAX_SAMPLES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  input  fifo_stat_t q_stat,
  output logic       push,
  output job_t       push_job
);

  localparam int PAIRS = FIBERS / 2;
  localparam int SPW   = $clog2(MAX_SAMPLES + 1);
  localparam int PRW   = $clog2(PAIRS + 1);
  localparam int FXW   = (PRW + 1 > FIBER_W) ? PRW + 1 : FIBER_W;
  localparam int SXW   = (SPW > SIDX_W) ? SPW : SIDX_W;

  logic [SPW-1:0] spc_r, spc_nxt;
  logic [SPW-1:0] sc_r, sc_nxt;
  logic [PRW-1:0] pair_r, pair_nxt;
  logic [2:0]     pos_r, pos_nxt;
  logic [31:0]    store_r [STORE_WORDS];

  logic           acc;
  logic           active;
  logic [FXW-1:0] fib_ext;
  logic [SXW-1:0] sidx_ext;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign active   = (spc_r != '0) && (pair_r < PRW'(PAIRS));
  assign push     = acc && (in_data.kind == KIND_DATA) && active &&
                    (pos_r == 3'(STORE_WORDS));

  // group request payload
  assign fib_ext  = FXW'({pair_r, 1'b0});
  assign sidx_ext = SXW'(sc_r);
  always_comb begin
    push_job.grp          = {store_r[0], store_r[1], store_r[2], store_r[3],
                             store_r[4], in_data.word};
    push_job.pair_lo      = fib_ext[FIBER_W-1:1];
    push_job.sample_index = sidx_ext[SIDX_W-1:0];
  end

  // counter updates
  always_comb begin
    spc_nxt  = spc_r;
    sc_nxt   = sc_r;
    pair_nxt = pair_r;
    pos_nxt  = pos_r;
    if (acc) begin
      if (in_data.kind == KIND_HEADER) begin
        spc_nxt  = (in_data.word > 32'(MAX_SAMPLES)) ? SPW'(MAX_SAMPLES)
                                                     : in_data.word[SPW-1:0];
        sc_nxt   = '0;
        pair_nxt = '0;
        pos_nxt  = '0;
      end else if (active) begin
        if (pos_r < 3'(STORE_WORDS)) begin
          pos_nxt = pos_r + 3'd1;
        end else begin
          pos_nxt = '0;
          if (sc_r + SPW'(1) >= spc_r) begin
            sc_nxt   = '0;
            pair_nxt = pair_r + PRW'(1);
          end else begin
            sc_nxt = sc_r + SPW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r  <= '0;
      sc_r   <= '0;
      pair_r <= '0;
      pos_r  <= '0;
    end else begin
      spc_r  <= spc_nxt;
      sc_r   <= sc_nxt;
      pair_r <= pair_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // word store, no reset
  always_ff @(posedge clk) begin
    if (acc && (in_data.kind == KIND_DATA) && active &&
        (pos_r < 3'(STORE_WORDS))) begin
      store_r[pos_r] <= in_data.word;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 3'(STORE_WORDS))
    else $error("word position out of range");
  a_sc_below: assert property (@(posedge clk) disable iff (!rst_n)
    (spc_r != '0) |-> (sc_r < spc_r))
    else $error("sample counter reached count");
  a_header_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.kind == KIND_HEADER) |=> (pos_r == '0 && pair_r == '0))
    else $error("header did not clear counters");
`endif

endmodule

// ===== src/swd_fifo.sv =====
// ----------------------------------------------------------------------------
// swd_fifo
// Two-entry queue of group requests between front and back end.
// ----------------------------------------------------------------------------
module swd_fifo import swd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       pop_job,
  output fifo_stat_t stat
);

  job_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_job    = mem_r[rd_r];

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r ^ do_push;
    rd_nxt  = rd_r ^ do_pop;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_r == rd_r))
    else $error("queue pointers disagree with count");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");
`endif

endmodule

// ===== src/swd_back.sv =====
// ----------------------------------------------------------------------------
// swd_back
// Takes one group at a time from the queue and sends its sixteen samples,
// one per cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module swd_back import swd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t q_stat,
  input  job_t       pop_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  job_t           cur_r;
  logic           busy_r, busy_nxt;
  logic [M_W-1:0] m_r, m_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_t           out_r;

  logic           adv;
  logic           last;
  logic           load;
  logic [7:0]     base;
  out_t           smp;

  assign adv  = busy_r && (!out_valid_r || out_ready);
  assign last = (m_r == M_W'(GROUP_SAMPLES - 1));
  assign pop  = !busy_r || (adv && last);
  assign load = pop && !q_stat.empty;

  // sample m sits at group bits 191-12m down to 180-12m
  assign base = {1'b0, ~m_r, 3'b000} + {2'b00, ~m_r, 2'b00};

  always_comb begin
    smp.fiber         = {cur_r.pair_lo, fiber_sel(m_r)};
    smp.channel       = chan_sel(m_r);
    smp.channel_index = {smp.fiber, smp.channel};
    smp.sample_index  = cur_r.sample_index;
    smp.sample_value  = cur_r.grp[base +: SAMPLE_W];
    smp.last_of_group = last;
  end

  // sequencing
  always_comb begin
    busy_nxt      = busy_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      m_nxt         = m_r + M_W'(1);
      out_valid_nxt = 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      m_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= pop_job;
    end
    if (adv) begin
      out_r <= smp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_idle_m_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (m_r == '0))
    else $error("sample index moved while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last && q_stat.empty) |=> !busy_r)
    else $error("group did not end after sixteenth sample");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> (out_valid && out_data.last_of_group))
    else $error("last sample not flagged");
`endif

endmodule

// ===== src/sample_word_deinterleaver_top.sv =====
// ----------------------------------------------------------------------------
// sample_word_deinterleaver_top
// Unpacks 32-bit fragment words into 12-bit samples with fiber, channel and
// sample position; six data words make one group of sixteen samples.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+--------------------------------
//  input   | in_valid, in_ready, in_data   | in_t  : kind, word
//  output  | out_valid, out_ready, out_data| out_t : fiber .. last_of_group
//
//  a word is taken whenever in_valid and in_ready are both high
//  a completed group goes to a two-entry queue; the back end sends one sample
//  per cycle while out_ready allows, sixteen samples for each six-word group
//  the output register rate is set by the single sample extraction unit and
//  by out_ready; in_ready drops only while the queue holds two groups
//  synchronous active-low reset clears counters, queue and output valid
// ----------------------------------------------------------------------------
module sample_word_deinterleaver_top import swd_pkg::*; #(
  parameter int FIBERS      = 20,
  parameter int MAX_SAMPLES = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  fifo_stat_t q_stat;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       pop_job;

  // request intake and grouping
  swd_front #(
    .FIBERS      (FIBERS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // group queue
  swd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  // sample emission
  swd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
